/* rtl/core/multi_timer_table_core_macros.svh */
// Assertion macros for the timer table core.
// Used by the top level only; needs nothing else.
`ifndef MULTI_TIMER_TABLE_CORE_MACROS_SVH
`define MULTI_TIMER_TABLE_CORE_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define TMT_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define TMT_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/core/tmt_pkg.sv */
// Shared types, codes and sizes for the timer table core.
// No dependencies.
package tmt_pkg;

    localparam int SLOTS  = 16;
    localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CNT_W  = $clog2(SLOTS + 1);

    localparam int FLAG_DEL = 0;
    localparam int FLAG_FIN = 1;

    typedef logic [SLOT_W-1:0] t_slot_idx;
    typedef logic [15:0]       t_handle;
    typedef logic [31:0]       t_ms;

    typedef enum logic [2:0] {
        MODE_ADD      = 3'd0,
        MODE_REMOVE   = 3'd1,
        MODE_UPDATE   = 3'd2,
        MODE_STATUS   = 3'd3,
        MODE_PREPARE  = 3'd4,
        MODE_CHECK    = 3'd5,
        MODE_DISPATCH = 3'd6
    } t_mode;

    typedef enum logic [1:0] {
        RC_OK        = 2'd0,
        RC_FULL      = 2'd1,
        RC_NOT_FOUND = 2'd2
    } t_res_code;

    typedef enum logic [1:0] {
        TS_INVALID  = 2'd0,
        TS_RUNNING  = 2'd1,
        TS_FINISHED = 2'd2
    } t_tstat;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ADD,
        ST_FIND,
        ST_MODIFY,
        ST_SCAN,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic [1:0] flags;
        logic       periodic;
        t_handle    handle;
        t_ms        interval;
        t_ms        remaining;
        t_ms        stamp;
        logic [1:0] status;
    } t_slot_rec;

    typedef struct packed {
        logic      alloc;
        logic      drop;
        logic      clr_pend_all;
        t_slot_idx idx;
        t_handle   handle;
    } t_tag_cmd;

    typedef struct packed {
        logic [SLOTS-1:0] used;
        logic [SLOTS-1:0] pending;
        logic             free_hit;
        t_slot_idx        free_idx;
        logic             match_hit;
        t_slot_idx        match_idx;
    } t_tag_stat;

    function automatic t_slot_rec arm_rec(t_handle handle, logic kind, t_ms ms, t_ms now);
        t_slot_rec rec;
        rec.flags     = 2'b00;
        rec.periodic  = kind;
        rec.handle    = handle;
        rec.interval  = ms;
        rec.remaining = ms;
        rec.stamp     = now;
        rec.status    = TS_RUNNING;
        return rec;
    endfunction

endpackage

/* rtl/core/tmt_slot_ram.sv */
// Slot record memory: one write port, one registered read port.
// Depends on tmt_pkg.
module tmt_slot_ram
    import tmt_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_wr_en,
    input  t_slot_idx i_wr_addr,
    input  t_slot_rec i_wr_data,
    input  logic      i_rd_en,
    input  t_slot_idx i_rd_addr,
    output t_slot_rec o_rd_data
);

    t_slot_rec r_mem [SLOTS];
    t_slot_rec r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

/* rtl/core/tmt_tag_cam.sv */
// Slot occupancy bits and handle tags with id lookup and free-slot search.
// Depends on tmt_pkg.
module tmt_tag_cam
    import tmt_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_tag_cmd  i_cmd,
    input  t_handle   i_lookup_id,
    output t_tag_stat o_stat
);

    logic [SLOTS-1:0] r_used;
    logic [SLOTS-1:0] n_used;
    logic [SLOTS-1:0] r_pending;
    logic [SLOTS-1:0] n_pending;
    t_handle          r_tag [SLOTS];

    always_comb begin
        n_used    = r_used;
        n_pending = r_pending;
        if (i_cmd.clr_pend_all) begin
            n_pending = '0;
        end
        if (i_cmd.alloc) begin
            n_used[i_cmd.idx]    = 1'b1;
            n_pending[i_cmd.idx] = 1'b1;
        end
        if (i_cmd.drop) begin
            n_used[i_cmd.idx]    = 1'b0;
            n_pending[i_cmd.idx] = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used    <= '0;
            r_pending <= '0;
        end else begin
            r_used    <= n_used;
            r_pending <= n_pending;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.alloc) begin
            r_tag[i_cmd.idx] <= i_cmd.handle;
        end
    end

    // Pending matches win over active ones; lowest slot wins within each group.
    always_comb begin
        logic      hit;
        logic      pend_hit;
        logic      act_hit;
        t_slot_idx pend_idx;
        t_slot_idx act_idx;
        logic      free_hit;
        t_slot_idx free_idx;
        pend_hit = 1'b0;
        act_hit  = 1'b0;
        pend_idx = '0;
        act_idx  = '0;
        free_hit = 1'b0;
        free_idx = '0;
        for (int i = SLOTS - 1; i >= 0; i--) begin
            hit = r_used[i] && (r_tag[i] == i_lookup_id) && (i_lookup_id != '0);
            if (hit && r_pending[i]) begin
                pend_hit = 1'b1;
                pend_idx = t_slot_idx'(i);
            end
            if (hit && !r_pending[i]) begin
                act_hit = 1'b1;
                act_idx = t_slot_idx'(i);
            end
            if (!r_used[i]) begin
                free_hit = 1'b1;
                free_idx = t_slot_idx'(i);
            end
        end
        o_stat.used      = r_used;
        o_stat.pending   = r_pending;
        o_stat.free_hit  = free_hit;
        o_stat.free_idx  = free_idx;
        o_stat.match_hit = pend_hit || act_hit;
        o_stat.match_idx = pend_hit ? pend_idx : act_idx;
    end

endmodule

/* rtl/core/multi_timer_table_core.sv */
// Top level of the timer table: operation sequencer and output register.
// Depends on tmt_pkg, tmt_slot_ram, tmt_tag_cam and the assertion macros.
//
// Usage: one operation per input transfer (i_in_valid/o_in_ready), carrying
// mode, timer id, kind, interval and the current millisecond time. Results
// leave through one output register (o_out_valid/i_out_ready); o_last marks
// the final result of an operation. Dispatch gives one result per fired
// timer followed by a closing result; every other mode gives one result.
// Steps, from input transfer to the edge that loads the result: add
// allocates a slot in ST_ADD; remove, update and status do a CAM lookup
// with record read in ST_FIND, then write back in ST_MODIFY; prepare,
// check and dispatch walk all SLOTS records one slot per cycle in ST_SCAN
// while the receiver stalls no dispatch result, and then close in ST_DONE.
// The next transfer is taken the cycle after the final result is loaded,
// and that result may still wait in the output register.
// A receiver stall holds the output register and, during dispatch, freezes
// the slot walk until the result is taken.
// Reset: synchronous, active low; all slots free, id counter cleared, no
// memory clearing pass is needed.
`include "multi_timer_table_core_macros.svh"

module multi_timer_table_core
    import tmt_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [2:0]  i_mode,
    input  logic [15:0] i_timer_id,
    input  logic        i_kind,
    input  logic [31:0] i_interval_ms,
    input  logic [31:0] i_now_ms,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [15:0] o_result_id,
    output logic [1:0]  o_result_code,
    output logic [1:0]  o_timer_status,
    output logic [31:0] o_timeout_ms,
    output logic        o_any_ready,
    output logic        o_fired,
    output logic        o_last
);

    t_state      r_state;
    t_state      n_state;
    logic [2:0]  r_mode;
    t_handle     r_id;
    logic        r_kind;
    t_ms         r_interval;
    t_ms         r_now;
    t_ms         r_least;
    t_ms         n_least;
    logic        r_ready;
    logic        n_ready;
    t_handle     r_next_handle;
    t_handle     n_next_handle;
    logic [CNT_W-1:0] r_rd_cnt;
    logic [CNT_W-1:0] n_rd_cnt;
    logic        r_ev_valid;
    logic        n_ev_valid;
    t_slot_idx   r_ev_idx;
    t_slot_idx   n_ev_idx;
    t_slot_idx   r_sel;
    t_slot_idx   n_sel;
    logic        r_sel_pend;
    logic        n_sel_pend;

    logic        r_out_valid;
    logic        n_out_valid;
    t_handle     r_out_id;
    t_handle     n_out_id;
    logic [1:0]  r_out_code;
    logic [1:0]  n_out_code;
    logic [1:0]  r_out_status;
    logic [1:0]  n_out_status;
    t_ms         r_out_timeout;
    t_ms         n_out_timeout;
    logic        r_out_any;
    logic        n_out_any;
    logic        r_out_fired;
    logic        n_out_fired;
    logic        r_out_last;
    logic        n_out_last;

    logic        emit;
    t_handle     res_id;
    logic [1:0]  res_code;
    logic [1:0]  res_status;
    t_ms         res_timeout;
    logic        res_any;
    logic        res_fired;
    logic        res_last;

    logic        mem_wr_en;
    t_slot_idx   mem_wr_addr;
    t_slot_rec   mem_wr_data;
    logic        mem_rd_en;
    t_slot_idx   mem_rd_addr;
    t_slot_rec   rec;
    t_tag_cmd    tag_cmd;
    t_tag_stat   tag_stat;

    logic        in_fire;
    logic        out_free;
    logic        issue;
    logic        ev_used;
    logic        ev_pend;
    logic        ev_fire;
    logic        stall;
    t_ms         delta;
    t_ms         rem_sub;
    t_handle     new_handle;

    tmt_slot_ram u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (mem_wr_en),
        .i_wr_addr (mem_wr_addr),
        .i_wr_data (mem_wr_data),
        .i_rd_en   (mem_rd_en),
        .i_rd_addr (mem_rd_addr),
        .o_rd_data (rec)
    );

    tmt_tag_cam u_cam (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (tag_cmd),
        .i_lookup_id (r_id),
        .o_stat      (tag_stat)
    );

    assign o_in_ready = (r_state == ST_IDLE);
    assign in_fire    = i_in_valid && o_in_ready;
    assign out_free   = !r_out_valid || i_out_ready;
    assign issue      = (r_rd_cnt != CNT_W'(SLOTS));
    assign ev_used    = tag_stat.used[r_ev_idx];
    assign ev_pend    = tag_stat.pending[r_ev_idx];
    assign delta      = r_now - rec.stamp;
    assign rem_sub    = rec.remaining - delta;
    assign new_handle = (r_next_handle == '1) ? 16'd1 : r_next_handle + 16'd1;
    assign ev_fire    = r_ev_valid && (r_mode == MODE_DISPATCH) && ev_used && !ev_pend
                        && (rec.remaining == '0) && (rec.flags == 2'b00);
    assign stall      = ev_fire && !out_free;

    always_comb begin
        n_state       = r_state;
        n_least       = r_least;
        n_ready       = r_ready;
        n_next_handle = r_next_handle;
        n_rd_cnt      = r_rd_cnt;
        n_ev_valid    = r_ev_valid;
        n_ev_idx      = r_ev_idx;
        n_sel         = r_sel;
        n_sel_pend    = r_sel_pend;

        emit        = 1'b0;
        res_id      = '0;
        res_code    = RC_OK;
        res_status  = TS_INVALID;
        res_timeout = '0;
        res_any     = 1'b0;
        res_fired   = 1'b0;
        res_last    = 1'b1;

        mem_wr_en   = 1'b0;
        mem_wr_addr = r_ev_idx;
        mem_wr_data = rec;
        mem_rd_en   = 1'b0;
        mem_rd_addr = r_rd_cnt[SLOT_W-1:0];
        tag_cmd     = '0;

        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_least    = '1;
                    n_ready    = 1'b0;
                    n_rd_cnt   = '0;
                    n_ev_valid = 1'b0;
                    unique case (i_mode) inside
                        MODE_ADD:                              n_state = ST_ADD;
                        MODE_REMOVE, MODE_UPDATE, MODE_STATUS: n_state = ST_FIND;
                        MODE_PREPARE, MODE_CHECK, MODE_DISPATCH: n_state = ST_SCAN;
                        default:                               n_state = ST_DONE;
                    endcase
                end
            end
            ST_ADD: begin
                if (out_free) begin
                    emit    = 1'b1;
                    n_state = ST_IDLE;
                    if (tag_stat.free_hit) begin
                        tag_cmd.alloc  = 1'b1;
                        tag_cmd.idx    = tag_stat.free_idx;
                        tag_cmd.handle = new_handle;
                        mem_wr_en      = 1'b1;
                        mem_wr_addr    = tag_stat.free_idx;
                        mem_wr_data    = arm_rec(new_handle, r_kind, r_interval, r_now);
                        n_next_handle  = new_handle;
                        res_id         = new_handle;
                    end else begin
                        res_code = RC_FULL;
                    end
                end
            end
            ST_FIND: begin
                if (tag_stat.match_hit) begin
                    mem_rd_en   = 1'b1;
                    mem_rd_addr = tag_stat.match_idx;
                    n_sel       = tag_stat.match_idx;
                    n_sel_pend  = tag_stat.pending[tag_stat.match_idx];
                    n_state     = ST_MODIFY;
                end else if (out_free) begin
                    emit     = 1'b1;
                    res_code = RC_NOT_FOUND;
                    n_state  = ST_IDLE;
                end
            end
            ST_MODIFY: begin
                if (out_free) begin
                    emit        = 1'b1;
                    n_state     = ST_IDLE;
                    mem_wr_addr = r_sel;
                    unique case (r_mode)
                        MODE_REMOVE: begin
                            if (r_sel_pend) begin
                                // pending timers are freed at once
                                tag_cmd.drop = 1'b1;
                                tag_cmd.idx  = r_sel;
                            end else begin
                                mem_wr_en                   = 1'b1;
                                mem_wr_data.flags[FLAG_DEL] = 1'b1;
                                mem_wr_data.status          = TS_INVALID;
                            end
                        end
                        MODE_UPDATE: begin
                            mem_wr_en   = 1'b1;
                            mem_wr_data = arm_rec(rec.handle, r_kind, r_interval, r_now);
                        end
                        MODE_STATUS: res_status = rec.status;
                        default: ;
                    endcase
                end
            end
            ST_SCAN: begin
                if (!stall) begin
                    if (r_ev_valid) begin
                        unique case (r_mode)
                            MODE_PREPARE: begin
                                if (ev_used) begin
                                    if (rec.flags[FLAG_DEL]) begin
                                        tag_cmd.drop = 1'b1;
                                        tag_cmd.idx  = r_ev_idx;
                                    end else if (rec.remaining < r_least) begin
                                        n_least = rec.remaining;
                                    end
                                end
                            end
                            MODE_CHECK: begin
                                if (ev_used && !ev_pend) begin
                                    mem_wr_en         = 1'b1;
                                    mem_wr_data.stamp = r_now;
                                    if (delta > rec.remaining) begin
                                        mem_wr_data.remaining = '0;
                                        n_ready               = 1'b1;
                                    end else begin
                                        mem_wr_data.remaining = rem_sub;
                                    end
                                end
                            end
                            MODE_DISPATCH: begin
                                if (ev_fire) begin
                                    mem_wr_en             = 1'b1;
                                    mem_wr_data.remaining = rec.interval;
                                    if (!rec.periodic) begin
                                        mem_wr_data.flags[FLAG_FIN] = 1'b1;
                                        mem_wr_data.status          = TS_FINISHED;
                                    end
                                    emit      = 1'b1;
                                    res_id    = rec.handle;
                                    res_fired = 1'b1;
                                    res_last  = 1'b0;
                                end
                            end
                            default: ;
                        endcase
                    end
                    // read the next slot while the current one is written back
                    if (issue) begin
                        mem_rd_en = 1'b1;
                        n_rd_cnt  = r_rd_cnt + CNT_W'(1);
                        n_ev_idx  = r_rd_cnt[SLOT_W-1:0];
                    end else begin
                        n_state = ST_DONE;
                    end
                    n_ev_valid = issue;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    emit    = 1'b1;
                    n_state = ST_IDLE;
                    if (r_mode == MODE_PREPARE) begin
                        tag_cmd.clr_pend_all = 1'b1;
                        res_timeout          = r_least;
                    end
                    if (r_mode == MODE_CHECK) begin
                        res_any = r_ready;
                    end
                end
            end
            default: n_state = ST_IDLE;
        endcase

        n_out_valid   = r_out_valid && !i_out_ready;
        n_out_id      = r_out_id;
        n_out_code    = r_out_code;
        n_out_status  = r_out_status;
        n_out_timeout = r_out_timeout;
        n_out_any     = r_out_any;
        n_out_fired   = r_out_fired;
        n_out_last    = r_out_last;
        if (emit) begin
            n_out_valid   = 1'b1;
            n_out_id      = res_id;
            n_out_code    = res_code;
            n_out_status  = res_status;
            n_out_timeout = res_timeout;
            n_out_any     = res_any;
            n_out_fired   = res_fired;
            n_out_last    = res_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= ST_IDLE;
            r_next_handle <= '0;
            r_rd_cnt      <= '0;
            r_ev_valid    <= 1'b0;
            r_out_valid   <= 1'b0;
        end else begin
            r_state       <= n_state;
            r_next_handle <= n_next_handle;
            r_rd_cnt      <= n_rd_cnt;
            r_ev_valid    <= n_ev_valid;
            r_out_valid   <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_mode     <= i_mode;
            r_id       <= i_timer_id;
            r_kind     <= i_kind;
            r_interval <= i_interval_ms;
            r_now      <= i_now_ms;
        end
        r_least       <= n_least;
        r_ready       <= n_ready;
        r_ev_idx      <= n_ev_idx;
        r_sel         <= n_sel;
        r_sel_pend    <= n_sel_pend;
        r_out_id      <= n_out_id;
        r_out_code    <= n_out_code;
        r_out_status  <= n_out_status;
        r_out_timeout <= n_out_timeout;
        r_out_any     <= n_out_any;
        r_out_fired   <= n_out_fired;
        r_out_last    <= n_out_last;
    end

    assign o_out_valid    = r_out_valid;
    assign o_result_id    = r_out_id;
    assign o_result_code  = r_out_code;
    assign o_timer_status = r_out_status;
    assign o_timeout_ms   = r_out_timeout;
    assign o_any_ready    = r_out_any;
    assign o_fired        = r_out_fired;
    assign o_last         = r_out_last;

    `TMT_ASSERT_IMP(a_no_rw_collide, i_clk, i_rst_n, mem_wr_en && mem_rd_en, mem_wr_addr != mem_rd_addr, "record read and write hit the same slot")
    `TMT_ASSERT_IMP(a_emit_has_room, i_clk, i_rst_n, emit, out_free, "result produced while output register is occupied")
    `TMT_ASSERT_IMP(a_alloc_free_slot, i_clk, i_rst_n, tag_cmd.alloc, !tag_stat.used[tag_cmd.idx], "add allocated a slot that is in use")
    `TMT_ASSERT_NXT(a_last_ends_item, i_clk, i_rst_n, emit && res_last, r_state == ST_IDLE, "final result did not return the sequencer to idle")

endmodule

/* test/tb_top.sv */
// Self-checking bench for multi_timer_table_core: one timer table shadow
// predicts every result. Depends on tmt_pkg and the core RTL only.
`timescale 1ns / 1ps

module tb_top
    import tmt_pkg::*;
();

    typedef struct packed {
        logic [15:0] id;
        logic [1:0]  code;
        logic [1:0]  tstat;
        logic [31:0] tmo;
        logic        rdy;
        logic        fired;
        logic        last;
    } t_timer_result;

    // Shadow copy of the timer table plus the queue of results it owes.
    class timer_table_shadow;
        bit        used [SLOTS];
        bit        pend [SLOTS];
        bit [1:0]  flags [SLOTS];
        bit        periodic [SLOTS];
        bit [15:0] handle [SLOTS];
        bit [31:0] interval [SLOTS];
        bit [31:0] remaining [SLOTS];
        bit [31:0] stamp [SLOTS];
        bit [1:0]  tstat [SLOTS];
        bit [15:0] next_handle;
        t_timer_result due_results [$];
        int n_err;
        int n_results;
        int n_fired;
        int n_full;

        function int find_slot(bit [15:0] id);
            int i;
            if (id == 16'd0) return -1;
            for (i = 0; i < SLOTS; i++)
                if (used[i] && pend[i] && handle[i] == id) return i;
            for (i = 0; i < SLOTS; i++)
                if (used[i] && !pend[i] && handle[i] == id) return i;
            return -1;
        endfunction

        function int free_slots();
            int i;
            int n;
            n = 0;
            for (i = 0; i < SLOTS; i++)
                if (!used[i]) n++;
            return n;
        endfunction

        function void arm(int s, bit kind, bit [31:0] ms, bit [31:0] now);
            flags[s]     = 2'b00;
            periodic[s]  = kind;
            interval[s]  = ms;
            remaining[s] = ms;
            stamp[s]     = now;
            tstat[s]     = TS_RUNNING;
        endfunction

        function void owe(logic [15:0] id, logic [1:0] code, logic [1:0] st,
                          logic [31:0] tmo, logic rdy, logic fired, logic last);
            t_timer_result r;
            r = '{id, code, st, tmo, rdy, fired, last};
            due_results.push_back(r);
        endfunction

        function void apply_op(t_mode mode, bit [15:0] id, bit kind, bit [31:0] ms,
                               bit [31:0] now);
            int s;
            int i;
            bit [31:0] least;
            bit [31:0] delta;
            bit ready;
            case (mode)
                MODE_ADD: begin
                    s = -1;
                    for (i = SLOTS - 1; i >= 0; i--)
                        if (!used[i]) s = i;
                    if (s < 0) begin
                        n_full++;
                        owe(16'd0, RC_FULL, TS_INVALID, 32'd0, 1'b0, 1'b0, 1'b1);
                    end else begin
                        next_handle++;
                        // skip zero on wrap
                        if (next_handle == 16'd0) next_handle = 16'd1;
                        used[s]   = 1'b1;
                        pend[s]   = 1'b1;
                        handle[s] = next_handle;
                        arm(s, kind, ms, now);
                        owe(next_handle, RC_OK, TS_INVALID, 32'd0, 1'b0, 1'b0, 1'b1);
                    end
                end
                MODE_REMOVE, MODE_UPDATE, MODE_STATUS: begin
                    s = find_slot(id);
                    if (s < 0) begin
                        owe(16'd0, RC_NOT_FOUND, TS_INVALID, 32'd0, 1'b0, 1'b0, 1'b1);
                    end else begin
                        if (mode == MODE_REMOVE) begin
                            if (pend[s]) begin
                                used[s] = 1'b0;
                                pend[s] = 1'b0;
                            end else begin
                                // active timers linger until the next prepare
                                flags[s][FLAG_DEL] = 1'b1;
                                tstat[s] = TS_INVALID;
                            end
                        end else if (mode == MODE_UPDATE) begin
                            arm(s, kind, ms, now);
                        end
                        owe(16'd0, RC_OK, (mode == MODE_STATUS) ? tstat[s] : TS_INVALID,
                            32'd0, 1'b0, 1'b0, 1'b1);
                    end
                end
                MODE_PREPARE: begin
                    least = 32'hFFFF_FFFF;
                    for (i = 0; i < SLOTS; i++) begin
                        pend[i] = 1'b0;
                        if (used[i]) begin
                            if (flags[i][FLAG_DEL]) used[i] = 1'b0;
                            else if (remaining[i] < least) least = remaining[i];
                        end
                    end
                    owe(16'd0, RC_OK, TS_INVALID, least, 1'b0, 1'b0, 1'b1);
                end
                MODE_CHECK: begin
                    ready = 1'b0;
                    for (i = 0; i < SLOTS; i++) begin
                        if (used[i] && !pend[i]) begin
                            delta = now - stamp[i];
                            if (delta > remaining[i]) begin
                                remaining[i] = 32'd0;
                                ready = 1'b1;
                            end else begin
                                remaining[i] = remaining[i] - delta;
                            end
                            stamp[i] = now;
                        end
                    end
                    owe(16'd0, RC_OK, TS_INVALID, 32'd0, ready, 1'b0, 1'b1);
                end
                MODE_DISPATCH: begin
                    for (i = 0; i < SLOTS; i++) begin
                        if (used[i] && !pend[i] && remaining[i] == 32'd0 && flags[i] == 2'b00) begin
                            remaining[i] = interval[i];
                            n_fired++;
                            owe(handle[i], RC_OK, TS_INVALID, 32'd0, 1'b0, 1'b1, 1'b0);
                            if (!periodic[i]) begin
                                flags[i][FLAG_FIN] = 1'b1;
                                tstat[i] = TS_FINISHED;
                            end
                        end
                    end
                    owe(16'd0, RC_OK, TS_INVALID, 32'd0, 1'b0, 1'b0, 1'b1);
                end
                default: owe(16'd0, RC_OK, TS_INVALID, 32'd0, 1'b0, 1'b0, 1'b1);
            endcase
        endfunction

        task report(string msg);
            n_err++;
            if (n_err <= 40) $display("%0t mismatch: %s", $time, msg);
        endtask

        task compare_result(t_timer_result got);
            t_timer_result want;
            n_results++;
            if (due_results.size() == 0) begin
                report($sformatf("result %0d arrived with nothing owed (id %0h last %0b)",
                                 n_results, got.id, got.last));
                return;
            end
            want = due_results.pop_front();
            if (got.id !== want.id)
                report($sformatf("result %0d id %0h, want %0h", n_results, got.id, want.id));
            if (got.code !== want.code)
                report($sformatf("result %0d code %0d, want %0d", n_results, got.code, want.code));
            if (got.tstat !== want.tstat)
                report($sformatf("result %0d status %0d, want %0d", n_results, got.tstat,
                                 want.tstat));
            if (got.tmo !== want.tmo)
                report($sformatf("result %0d timeout %0h, want %0h", n_results, got.tmo,
                                 want.tmo));
            if (got.rdy !== want.rdy)
                report($sformatf("result %0d any_ready %0b, want %0b", n_results, got.rdy,
                                 want.rdy));
            if (got.fired !== want.fired)
                report($sformatf("result %0d fired %0b, want %0b", n_results, got.fired,
                                 want.fired));
            if (got.last !== want.last)
                report($sformatf("result %0d last %0b, want %0b", n_results, got.last,
                                 want.last));
        endtask
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_ready;
    logic [2:0]  i_mode = MODE_STATUS;
    logic [15:0] i_timer_id = 16'd0;
    logic        i_kind = 1'b0;
    logic [31:0] i_interval_ms = 32'd0;
    logic [31:0] i_now_ms = 32'd0;
    logic        o_out_valid;
    logic        i_out_ready = 1'b0;
    logic [15:0] o_result_id;
    logic [1:0]  o_result_code;
    logic [1:0]  o_timer_status;
    logic [31:0] o_timeout_ms;
    logic        o_any_ready;
    logic        o_fired;
    logic        o_last;

    timer_table_shadow shadow = new();
    bit        calm = 1'b0;
    bit [31:0] clock_ms = 32'd0;
    int        n_ops = 0;

    multi_timer_table_core i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_mode         (i_mode),
        .i_timer_id     (i_timer_id),
        .i_kind         (i_kind),
        .i_interval_ms  (i_interval_ms),
        .i_now_ms       (i_now_ms),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_result_id    (o_result_id),
        .o_result_code  (o_result_code),
        .o_timer_status (o_timer_status),
        .o_timeout_ms   (o_timeout_ms),
        .o_any_ready    (o_any_ready),
        .o_fired        (o_fired),
        .o_last         (o_last)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // mostly short idle stretches, now and then a long one
    function automatic int idle_len();
        if ($urandom_range(0, 99) < 85) return $urandom_range(1, 3);
        return $urandom_range(6, 40);
    endfunction

    function automatic bit [31:0] rand_interval();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70) return $urandom_range(0, 40);
        if (r < 85) return $urandom_range(0, 5);
        if (r < 95) return $urandom;
        return 32'hFFFF_FFFF;
    endfunction

    function automatic void advance_clock();
        int r;
        r = $urandom_range(0, 99);
        if (r < 80) clock_ms = clock_ms + $urandom_range(0, 15);
        else if (r < 95) clock_ms = clock_ms + $urandom_range(16, 300);
        else clock_ms = clock_ms + $urandom;
    endfunction

    // mostly a live handle, sometimes zero or a stray value
    function automatic bit [15:0] pick_id();
        int r;
        int s;
        r = $urandom_range(0, 99);
        if (r < 10) return 16'd0;
        if (r < 25 || shadow.free_slots() == SLOTS) return 16'($urandom);
        do s = $urandom_range(0, SLOTS - 1); while (!shadow.used[s]);
        return shadow.handle[s];
    endfunction

    task automatic send_op(t_mode mode, logic [15:0] id, logic kind, logic [31:0] ms,
                           logic [31:0] now);
        int gap;
        gap = 0;
        if (!calm && $urandom_range(0, 99) < 40) gap = idle_len();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid    <= 1'b1;
        i_mode        <= mode;
        i_timer_id    <= id;
        i_kind        <= kind;
        i_interval_ms <= ms;
        i_now_ms      <= now;
        do @(posedge i_clk); while (o_in_ready !== 1'b1);
        shadow.apply_op(mode, id, kind, ms, now);
        n_ops++;
    endtask

    // a few table edits, then prepare and some check/dispatch passes
    task automatic run_round();
        int n;
        int k;
        int r;
        calm = ($urandom_range(0, 3) == 0);
        n = $urandom_range(1, 4);
        for (k = 0; k < n; k++) begin
            r = $urandom_range(0, 99);
            if (r < 45)
                send_op(MODE_ADD, 16'($urandom), 1'($urandom), rand_interval(), clock_ms);
            else if (r < 65)
                send_op(MODE_REMOVE, pick_id(), 1'($urandom), $urandom, clock_ms);
            else if (r < 80)
                send_op(MODE_UPDATE, pick_id(), 1'($urandom), rand_interval(), clock_ms);
            else
                send_op(MODE_STATUS, pick_id(), 1'($urandom), $urandom, clock_ms);
        end
        send_op(MODE_PREPARE, 16'($urandom), 1'($urandom), $urandom, clock_ms);
        n = $urandom_range(1, 3);
        for (k = 0; k < n; k++) begin
            advance_clock();
            send_op(MODE_CHECK, 16'($urandom), 1'($urandom), $urandom, clock_ms);
            send_op(MODE_DISPATCH, 16'($urandom), 1'($urandom), $urandom, clock_ms);
            if ($urandom_range(0, 99) < 30)
                send_op(MODE_STATUS, pick_id(), 1'($urandom), $urandom, clock_ms);
        end
    endtask

    initial begin : result_sink
        int stall;
        t_timer_result got;
        stall = 0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_out_valid === 1'b1 && i_out_ready) begin
                got = '{o_result_id, o_result_code, o_timer_status, o_timeout_ms,
                        o_any_ready, o_fired, o_last};
                shadow.compare_result(got);
            end
            if (stall > 0) begin
                i_out_ready <= 1'b0;
                stall--;
            end else begin
                i_out_ready <= 1'b1;
                if (!calm && $urandom_range(0, 99) < 20) stall = idle_len();
            end
        end
    end

    initial begin : stimulus
        int start;
        bit [31:0] t0;

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // empty table, unknown ids, 32-bit extremes
        t0 = 32'hFFFF_FFF0;
        send_op(MODE_STATUS, 16'd0, 1'b0, 32'd0, 32'd0);
        send_op(MODE_REMOVE, 16'hFFFF, 1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_op(MODE_UPDATE, 16'h1234, 1'b1, 32'd7, t0);
        send_op(MODE_PREPARE, 16'd0, 1'b0, 32'd0, t0);
        send_op(MODE_CHECK, 16'd0, 1'b0, 32'd0, t0);
        send_op(MODE_DISPATCH, 16'd0, 1'b0, 32'd0, t0);
        send_op(MODE_ADD, 16'd0, 1'b0, 32'd0, t0);
        send_op(MODE_ADD, 16'd0, 1'b1, 32'd5, t0);
        send_op(MODE_ADD, 16'd0, 1'b0, 32'hFFFF_FFFF, t0);
        send_op(MODE_STATUS, 16'd1, 1'b0, 32'd0, t0);
        // pending timer goes away at once
        send_op(MODE_REMOVE, 16'd3, 1'b0, 32'd0, t0);
        send_op(MODE_STATUS, 16'd3, 1'b0, 32'd0, t0);
        send_op(MODE_PREPARE, 16'd0, 1'b0, 32'd0, t0);
        // time wraps through zero here
        send_op(MODE_CHECK, 16'd0, 1'b0, 32'd0, 32'd2);
        send_op(MODE_DISPATCH, 16'd0, 1'b0, 32'd0, 32'd2);
        send_op(MODE_STATUS, 16'd1, 1'b0, 32'd0, 32'd2);
        send_op(MODE_DISPATCH, 16'd0, 1'b0, 32'd0, 32'd2);
        send_op(MODE_UPDATE, 16'd1, 1'b1, 32'd3, 32'd2);
        // elapsed equals remainder: not ready, yet it fires on dispatch
        send_op(MODE_CHECK, 16'd0, 1'b0, 32'd0, 32'd5);
        send_op(MODE_DISPATCH, 16'd0, 1'b0, 32'd0, 32'd5);
        send_op(MODE_REMOVE, 16'd2, 1'b0, 32'd0, 32'd5);
        send_op(MODE_STATUS, 16'd2, 1'b0, 32'd0, 32'd5);
        send_op(MODE_PREPARE, 16'd0, 1'b0, 32'd0, 32'd5);
        send_op(MODE_UPDATE, 16'd2, 1'b0, 32'd9, 32'd5);
        clock_ms = 32'd5;

        start = n_ops;
        while (n_ops - start < 75) begin
            if ($urandom_range(0, 99) < 80) begin
                run_round();
            end else begin
                calm = 1'b0;
                send_op(t_mode'($urandom_range(0, 6)), 16'($urandom), 1'($urandom),
                        $urandom, $urandom);
            end
        end

        // fill the table, hit full, then free one slot again
        calm = 1'b1;
        send_op(MODE_PREPARE, 16'd0, 1'b0, 32'd0, clock_ms);
        while (shadow.free_slots() > 0)
            send_op(MODE_ADD, 16'd0, 1'($urandom), rand_interval(), clock_ms);
        send_op(MODE_ADD, 16'd0, 1'b1, 32'd1, clock_ms);
        send_op(MODE_REMOVE, shadow.handle[SLOTS - 1], 1'b0, 32'd0, clock_ms);
        send_op(MODE_PREPARE, 16'd0, 1'b0, 32'd0, clock_ms);
        i_in_valid <= 1'b0;

        while (shadow.due_results.size() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
        $display("tb_top summary: %0d operations, %0d results compared, %0d timer firings",
                 n_ops, shadow.n_results, shadow.n_fired);
        $display("tb_top summary: table found full %0d times", shadow.n_full);
        if (shadow.n_err == 0) begin
            $display("tb_top: clean");
        end else begin
            $display("tb_top: errors");
        end
        $finish;
    end

    initial begin : watchdog
        #50_000_000;
        $display("tb_top: errors");
        $finish;
    end

endmodule
